// File: rtl/core/mi4_pkg.sv
// ----------------------------------------------------------------------------
// mi4_pkg: shared types, constants and saturating helpers
// Word type, sequencer states and 64-bit saturating arithmetic used by the
// 4x4 adjugate inverter and its fixed-point multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package mi4_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int WORD_W         = 64;
    localparam int ELEM_COUNT     = 16;
    localparam int MINOR_COUNT    = 9;

    typedef logic signed [WORD_W-1:0] word_t;

    localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COF_RD,
        ST_COF_ISSUE,
        ST_COF_WAIT,
        ST_COF_WR,
        ST_DET_RD,
        ST_DET_ISSUE,
        ST_DET_WAIT,
        ST_DIV_INIT,
        ST_DIV,
        ST_EM_RD,
        ST_EM_ISSUE,
        ST_EM_WAIT
    } state_t;

    // Add with saturation to the signed word range
    function automatic word_t sat_add(input word_t a, input word_t b);
        word_t r;
        r = a + b;
        if (a[WORD_W-1] == b[WORD_W-1] && r[WORD_W-1] != a[WORD_W-1])
            return a[WORD_W-1] ? WORD_MIN : WORD_MAX;
        return r;
    endfunction

    // Subtract with saturation to the signed word range
    function automatic word_t sat_sub(input word_t a, input word_t b);
        word_t r;
        r = a - b;
        if (a[WORD_W-1] != b[WORD_W-1] && r[WORD_W-1] != a[WORD_W-1])
            return a[WORD_W-1] ? WORD_MIN : WORD_MAX;
        return r;
    endfunction

    // Negate, mapping the most negative word to the most positive
    function automatic word_t sat_neg(input word_t a);
        if (a == WORD_MIN)
            return WORD_MAX;
        return -a;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/mi4_qmul.sv
// ----------------------------------------------------------------------------
// mi4_qmul: sequential 64x64 fixed-point multiplier
// Forms the exact magnitude product from four 32x32 partial products, one per
// cycle, then rounds half away from zero to FRAC_BITS and saturates to 64 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module mi4_qmul #(
    parameter int FRAC_BITS = mi4_pkg::FRAC_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire mi4_pkg::word_t a,
    input  wire mi4_pkg::word_t b,
    output logic               done,
    output mi4_pkg::word_t     result
);

    localparam int PROD_W = 2 * mi4_pkg::WORD_W;
    localparam int HALF_W = mi4_pkg::WORD_W / 2;
    localparam logic [PROD_W-1:0] ROUND_ADD = PROD_W'(1) << (FRAC_BITS - 1);

    logic [mi4_pkg::WORD_W-1:0] ua_reg;
    logic [mi4_pkg::WORD_W-1:0] ub_reg;
    logic                       neg_reg;
    logic [PROD_W-1:0]          acc_reg;
    logic [1:0]                 cnt_reg;
    logic                       run_reg;
    logic                       fin_reg;
    logic                       done_reg;
    mi4_pkg::word_t             result_reg;

    logic [HALF_W-1:0]          pa;
    logic [HALF_W-1:0]          pb;
    logic [mi4_pkg::WORD_W-1:0] pp;
    logic [PROD_W-1:0]          pp_shift;
    logic [PROD_W-1:0]          rounded;
    logic [PROD_W-1:0]          scaled;
    logic                       over;
    mi4_pkg::word_t             final_val;

    // Select the halves for this partial product and align it
    always_comb
    begin
        pa = cnt_reg[1] ? ua_reg[mi4_pkg::WORD_W-1:HALF_W] : ua_reg[HALF_W-1:0];
        pb = cnt_reg[0] ? ub_reg[mi4_pkg::WORD_W-1:HALF_W] : ub_reg[HALF_W-1:0];
        pp = mi4_pkg::WORD_W'(pa) * mi4_pkg::WORD_W'(pb);
        case (cnt_reg)
            2'd0:    pp_shift = PROD_W'(pp);
            2'd3:    pp_shift = PROD_W'(pp) << mi4_pkg::WORD_W;
            default: pp_shift = PROD_W'(pp) << HALF_W;
        endcase
    end

    // Round, scale and saturate the finished product
    always_comb
    begin
        rounded = acc_reg + ROUND_ADD;
        scaled  = rounded >> FRAC_BITS;
        over    = |scaled[PROD_W-1:mi4_pkg::WORD_W-1];
        if (!neg_reg)
            final_val = over ? mi4_pkg::WORD_MAX
                             : mi4_pkg::word_t'(scaled[mi4_pkg::WORD_W-1:0]);
        else
            final_val = over ? mi4_pkg::WORD_MIN
                             : -mi4_pkg::word_t'(scaled[mi4_pkg::WORD_W-1:0]);
    end

    // Sequence the partial products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 2'd0;
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= run_reg && (cnt_reg == 2'd3);
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 2'd0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                    run_reg <= 1'b0;
            end
        end
    end

    // Hold operands, accumulate, capture the result
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ua_reg  <= a[mi4_pkg::WORD_W-1] ? 64'(-a) : 64'(a);
            ub_reg  <= b[mi4_pkg::WORD_W-1] ? 64'(-b) : 64'(b);
            neg_reg <= a[mi4_pkg::WORD_W-1] ^ b[mi4_pkg::WORD_W-1];
            acc_reg <= '0;
        end
        else if (run_reg)
            acc_reg <= acc_reg + pp_shift;
        if (fin_reg)
            result_reg <= final_val;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// File: rtl/core/matrix_inverse_4x4.sv
// ----------------------------------------------------------------------------
// matrix_inverse_4x4: 4x4 matrix inverse by the adjugate, fixed point
// Loads elements one per transaction, then forms cofactors, determinant,
// reciprocal and the sixteen scaled adjugate elements.
// ----------------------------------------------------------------------------
// Each load transaction (start high, busy low) writes one
// element. A load with start_compute set begins the inversion and raises busy
// until the sixteenth result appears; busy falls in the cycle that shows that
// result, so the next load can be taken in that cycle. Each of the 16 cofactors
// reads its 9 minor elements, forms nine products on the shared multiplier and
// is stored; then the determinant is summed along the first row, the
// bit-serial reciprocal divider runs and each result takes one more product
// (none when singular). Results appear one at a time
// with result_valid high for exactly one cycle; the receiver must take each
// one in that cycle, since the block cannot be held.
`default_nettype none

module matrix_inverse_4x4 #(
    parameter int DATA_WIDTH = mi4_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = mi4_pkg::FRAC_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [3:0]                   element_index,
    input  wire logic signed [DATA_WIDTH-1:0] element_value,
    input  wire logic                         start_compute,
    output logic                              result_valid,
    output logic [3:0]                        result_index,
    output logic signed [DATA_WIDTH-1:0]      result_value,
    output logic                              singular,
    output logic                              last_of_run
);

    localparam int W = mi4_pkg::WORD_W;
    localparam mi4_pkg::word_t HI_LIM = (mi4_pkg::word_t'(1) <<< (DATA_WIDTH - 1)) - 1;
    localparam mi4_pkg::word_t LO_LIM = -HI_LIM - 1;
    localparam logic [W-1:0]  NUM_ONE = W'(1) << (2 * FRAC_BITS);

    // Memories
    logic signed [DATA_WIDTH-1:0] mat_mem [mi4_pkg::ELEM_COUNT];
    mi4_pkg::word_t               cof_mem [mi4_pkg::ELEM_COUNT];
    logic signed [DATA_WIDTH-1:0] mat_q_reg;
    mi4_pkg::word_t               cof_q_reg;
    logic [3:0]                   mat_raddr;
    logic [3:0]                   cof_raddr;
    logic                         mat_we;
    logic                         cof_we;
    mi4_pkg::word_t               cof_wdata;

    // Control state
    mi4_pkg::state_t state_reg, state_next;
    logic [3:0] cof_idx_reg, cof_idx_next;
    logic [3:0] rd_cnt_reg, rd_cnt_next;
    logic [1:0] mr_reg, mr_next;
    logic [1:0] mc_reg, mc_next;
    logic [3:0] step_reg, step_next;
    logic [1:0] k_reg, k_next;
    logic [5:0] div_cnt_reg, div_cnt_next;
    logic [3:0] em_idx_reg, em_idx_next;
    logic       valid_reg, valid_next;
    logic       last_reg, last_next;
    logic       sing_reg, sing_next;

    // Datapath registers
    mi4_pkg::word_t minor_reg [mi4_pkg::MINOR_COUNT];
    mi4_pkg::word_t minor_next [mi4_pkg::MINOR_COUNT];
    mi4_pkg::word_t tmp_reg, tmp_next;
    mi4_pkg::word_t t0_reg, t0_next;
    mi4_pkg::word_t t1_reg, t1_next;
    mi4_pkg::word_t t2_reg, t2_next;
    mi4_pkg::word_t acc_reg, acc_next;
    mi4_pkg::word_t det_reg, det_next;
    mi4_pkg::word_t recip_reg, recip_next;
    logic [W-1:0]   den_reg, den_next;
    logic [W-1:0]   num_reg, num_next;
    logic [W-1:0]   rem_reg, rem_next;
    logic [W-1:0]   quo_reg, quo_next;
    logic           dneg_reg, dneg_next;
    logic [3:0]     ridx_reg, ridx_next;
    logic signed [DATA_WIDTH-1:0] rval_reg, rval_next;

    // Multiplier hookup
    logic           mul_start;
    mi4_pkg::word_t mul_a;
    mi4_pkg::word_t mul_b;
    logic           mul_done;
    mi4_pkg::word_t mul_p;

    // Scratch
    logic [1:0]     dr;
    logic [1:0]     dc;
    logic [1:0]     mrow;
    logic [1:0]     mcol;
    logic [W:0]     rem_sh;
    logic [W:0]     rem_dif;
    logic [W-1:0]   ud;
    mi4_pkg::word_t clamp_v;

    mi4_qmul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_qmul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .done   (mul_done),
        .result (mul_p)
    );

    // Matrix and cofactor memories, registered read
    always_ff @(posedge clk)
    begin
        if (mat_we)
            mat_mem[element_index] <= element_value;
        mat_q_reg <= mat_mem[mat_raddr];
        if (cof_we)
            cof_mem[cof_idx_reg] <= cof_wdata;
        cof_q_reg <= cof_mem[cof_raddr];
    end

    // Sequencer: next state, datapath updates, memory controls
    always_comb
    begin
        state_next   = state_reg;
        cof_idx_next = cof_idx_reg;
        rd_cnt_next  = rd_cnt_reg;
        mr_next      = mr_reg;
        mc_next      = mc_reg;
        step_next    = step_reg;
        k_next       = k_reg;
        div_cnt_next = div_cnt_reg;
        em_idx_next  = em_idx_reg;
        valid_next   = 1'b0;
        last_next    = 1'b0;
        sing_next    = sing_reg;
        minor_next   = minor_reg;
        tmp_next     = tmp_reg;
        t0_next      = t0_reg;
        t1_next      = t1_reg;
        t2_next      = t2_reg;
        acc_next     = acc_reg;
        det_next     = det_reg;
        recip_next   = recip_reg;
        den_next     = den_reg;
        num_next     = num_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        dneg_next    = dneg_reg;
        ridx_next    = ridx_reg;
        rval_next    = rval_reg;

        mat_we    = 1'b0;
        cof_we    = 1'b0;
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;

        dr        = cof_idx_reg[3:2];
        dc        = cof_idx_reg[1:0];
        mrow      = 2'(mr_reg + {1'b0, mr_reg >= dr});
        mcol      = 2'(mc_reg + {1'b0, mc_reg >= dc});
        mat_raddr = {2'b00, k_reg};
        cof_raddr = {em_idx_reg[1:0], em_idx_reg[3:2]};
        cof_wdata = (cof_idx_reg[2] ^ cof_idx_reg[0]) ? mi4_pkg::sat_neg(acc_reg) : acc_reg;

        rem_sh  = {rem_reg, num_reg[W-1]};
        rem_dif = rem_sh - {1'b0, den_reg};
        ud      = det_reg[W-1] ? W'(-det_reg) : W'(det_reg);
        clamp_v = mul_p;
        if (mul_p > HI_LIM)
            clamp_v = HI_LIM;
        if (mul_p < LO_LIM)
            clamp_v = LO_LIM;

        case (state_reg)
            mi4_pkg::ST_IDLE:
            begin
                // Take a load transaction
                if (start)
                begin
                    mat_we = 1'b1;
                    if (start_compute)
                    begin
                        state_next   = mi4_pkg::ST_COF_RD;
                        cof_idx_next = 4'd0;
                        rd_cnt_next  = 4'd0;
                        mr_next      = 2'd0;
                        mc_next      = 2'd0;
                    end
                end
            end

            mi4_pkg::ST_COF_RD:
            begin
                // Fetch the nine minor elements, capture each in the following cycle
                mat_raddr = {mrow, mcol};
                if (rd_cnt_reg != 4'd0)
                    minor_next[rd_cnt_reg - 4'd1] = W'(mat_q_reg);
                if (mc_reg == 2'd2)
                begin
                    mc_next = 2'd0;
                    mr_next = mr_reg + 2'd1;
                end
                else
                    mc_next = mc_reg + 2'd1;
                rd_cnt_next = rd_cnt_reg + 4'd1;
                if (rd_cnt_reg == 4'(mi4_pkg::MINOR_COUNT))
                begin
                    state_next = mi4_pkg::ST_COF_ISSUE;
                    step_next  = 4'd0;
                end
            end

            mi4_pkg::ST_COF_ISSUE:
            begin
                // Issue this step's product of the 3x3 expansion
                mul_start  = 1'b1;
                state_next = mi4_pkg::ST_COF_WAIT;
                case (step_reg)
                    4'd0:    begin mul_a = minor_reg[4]; mul_b = minor_reg[8]; end
                    4'd1:    begin mul_a = minor_reg[5]; mul_b = minor_reg[7]; end
                    4'd2:    begin mul_a = minor_reg[3]; mul_b = minor_reg[8]; end
                    4'd3:    begin mul_a = minor_reg[5]; mul_b = minor_reg[6]; end
                    4'd4:    begin mul_a = minor_reg[3]; mul_b = minor_reg[7]; end
                    4'd5:    begin mul_a = minor_reg[4]; mul_b = minor_reg[6]; end
                    4'd6:    begin mul_a = minor_reg[0]; mul_b = t0_reg; end
                    4'd7:    begin mul_a = minor_reg[1]; mul_b = t1_reg; end
                    default: begin mul_a = minor_reg[2]; mul_b = t2_reg; end
                endcase
            end

            mi4_pkg::ST_COF_WAIT:
            begin
                // Fold the product into the partial terms
                if (mul_done)
                begin
                    case (step_reg)
                        4'd1:    t0_next  = mi4_pkg::sat_sub(tmp_reg, mul_p);
                        4'd3:    t1_next  = mi4_pkg::sat_sub(tmp_reg, mul_p);
                        4'd5:    t2_next  = mi4_pkg::sat_sub(tmp_reg, mul_p);
                        4'd6:    acc_next = mul_p;
                        4'd7:    acc_next = mi4_pkg::sat_sub(acc_reg, mul_p);
                        4'd8:    acc_next = mi4_pkg::sat_add(acc_reg, mul_p);
                        default: tmp_next = mul_p;
                    endcase
                    step_next = step_reg + 4'd1;
                    if (step_reg == 4'd8)
                        state_next = mi4_pkg::ST_COF_WR;
                    else
                        state_next = mi4_pkg::ST_COF_ISSUE;
                end
            end

            mi4_pkg::ST_COF_WR:
            begin
                // Store the signed cofactor, advance to the next one or, after the last, to the determinant
                cof_we      = 1'b1;
                rd_cnt_next = 4'd0;
                mr_next     = 2'd0;
                mc_next     = 2'd0;
                if (cof_idx_reg == 4'd15)
                begin
                    state_next = mi4_pkg::ST_DET_RD;
                    k_next     = 2'd0;
                    det_next   = '0;
                end
                else
                begin
                    cof_idx_next = cof_idx_reg + 4'd1;
                    state_next   = mi4_pkg::ST_COF_RD;
                end
            end

            mi4_pkg::ST_DET_RD:
            begin
                // Read first-row element and its cofactor
                cof_raddr  = {2'b00, k_reg};
                state_next = mi4_pkg::ST_DET_ISSUE;
            end

            mi4_pkg::ST_DET_ISSUE:
            begin
                mul_start  = 1'b1;
                mul_a      = W'(mat_q_reg);
                mul_b      = cof_q_reg;
                state_next = mi4_pkg::ST_DET_WAIT;
            end

            mi4_pkg::ST_DET_WAIT:
            begin
                // Accumulate the determinant along the first row
                if (mul_done)
                begin
                    det_next = mi4_pkg::sat_add(det_reg, mul_p);
                    k_next   = k_reg + 2'd1;
                    if (k_reg == 2'd3)
                        state_next = mi4_pkg::ST_DIV_INIT;
                    else
                        state_next = mi4_pkg::ST_DET_RD;
                end
            end

            mi4_pkg::ST_DIV_INIT:
            begin
                // Set up the rounded reciprocal division, or flag singular
                sing_next    = (det_reg == '0);
                em_idx_next  = 4'd0;
                den_next     = ud;
                num_next     = NUM_ONE + (ud >> 1);
                rem_next     = '0;
                quo_next     = '0;
                dneg_next    = det_reg[W-1];
                div_cnt_next = '0;
                if (det_reg == '0)
                    state_next = mi4_pkg::ST_EM_RD;
                else
                    state_next = mi4_pkg::ST_DIV;
            end

            mi4_pkg::ST_DIV:
            begin
                // One quotient bit per cycle
                num_next = num_reg << 1;
                if (!rem_dif[W])
                begin
                    rem_next = rem_dif[W-1:0];
                    quo_next = {quo_reg[W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[W-1:0];
                    quo_next = {quo_reg[W-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + 6'd1;
                if (div_cnt_reg == 6'(W - 1))
                begin
                    recip_next = dneg_reg ? -mi4_pkg::word_t'(quo_next)
                                          : mi4_pkg::word_t'(quo_next);
                    state_next = mi4_pkg::ST_EM_RD;
                end
            end

            mi4_pkg::ST_EM_RD:
            begin
                // Read the transposed cofactor
                state_next = mi4_pkg::ST_EM_ISSUE;
            end

            mi4_pkg::ST_EM_ISSUE:
            begin
                if (sing_reg)
                begin
                    // Emit a zero element directly
                    valid_next  = 1'b1;
                    last_next   = (em_idx_reg == 4'd15);
                    ridx_next   = em_idx_reg;
                    rval_next   = '0;
                    em_idx_next = em_idx_reg + 4'd1;
                    state_next  = (em_idx_reg == 4'd15) ? mi4_pkg::ST_IDLE
                                                         : mi4_pkg::ST_EM_RD;
                end
                else
                begin
                    mul_start  = 1'b1;
                    mul_a      = cof_q_reg;
                    mul_b      = recip_reg;
                    state_next = mi4_pkg::ST_EM_WAIT;
                end
            end

            mi4_pkg::ST_EM_WAIT:
            begin
                // Saturate to the output width and emit
                if (mul_done)
                begin
                    valid_next  = 1'b1;
                    last_next   = (em_idx_reg == 4'd15);
                    ridx_next   = em_idx_reg;
                    rval_next   = clamp_v[DATA_WIDTH-1:0];
                    em_idx_next = em_idx_reg + 4'd1;
                    state_next  = (em_idx_reg == 4'd15) ? mi4_pkg::ST_IDLE
                                                         : mi4_pkg::ST_EM_RD;
                end
            end

            default:
            begin
                state_next = mi4_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= mi4_pkg::ST_IDLE;
            cof_idx_reg <= 4'd0;
            rd_cnt_reg  <= 4'd0;
            mr_reg      <= 2'd0;
            mc_reg      <= 2'd0;
            step_reg    <= 4'd0;
            k_reg       <= 2'd0;
            div_cnt_reg <= 6'd0;
            em_idx_reg  <= 4'd0;
            valid_reg   <= 1'b0;
            last_reg    <= 1'b0;
            sing_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cof_idx_reg <= cof_idx_next;
            rd_cnt_reg  <= rd_cnt_next;
            mr_reg      <= mr_next;
            mc_reg      <= mc_next;
            step_reg    <= step_next;
            k_reg       <= k_next;
            div_cnt_reg <= div_cnt_next;
            em_idx_reg  <= em_idx_next;
            valid_reg   <= valid_next;
            last_reg    <= last_next;
            sing_reg    <= sing_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        minor_reg <= minor_next;
        tmp_reg   <= tmp_next;
        t0_reg    <= t0_next;
        t1_reg    <= t1_next;
        t2_reg    <= t2_next;
        acc_reg   <= acc_next;
        det_reg   <= det_next;
        recip_reg <= recip_next;
        den_reg   <= den_next;
        num_reg   <= num_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        dneg_reg  <= dneg_next;
        ridx_reg  <= ridx_next;
        rval_reg  <= rval_next;
    end

    assign busy         = (state_reg != mi4_pkg::ST_IDLE);
    assign result_valid = valid_reg;
    assign result_index = ridx_reg;
    assign result_value = rval_reg;
    assign singular     = sing_reg;
    assign last_of_run  = last_reg;

`ifndef NO_ASSERTIONS
    // A result before the last one only appears during a run
    a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last_of_run) |-> busy)
        else $error("result strobe outside a run");

    // Only a load transaction that starts compute raises busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy == $past(start_compute)))
        else $error("busy does not follow the start transaction");

    // The last marker sits on the sixteenth strobe
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        last_of_run |-> (result_valid && result_index == 4'd15))
        else $error("last marker misplaced");

    // A singular run gives zero elements
    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && singular) |-> (result_value == '0))
        else $error("nonzero element on singular run");
`endif

endmodule

`default_nettype wire
